>>> hdl/bts_pkg.sv
// ----------------------------------------------------------------------------
// bts_pkg
// shared constants, codes and types of the bilinear texture sampler
// ----------------------------------------------------------------------------
package bts_pkg;

   localparam int MAX_SIDE    = 256;
   localparam int SIDE_W      = $clog2(MAX_SIDE) + 1;
   localparam int CELL_W      = $clog2(MAX_SIDE);
   localparam int ADDR_W      = 16;
   localparam int STORE_DEPTH = 1 << ADDR_W;
   localparam int TEXEL_W     = 24;
   localparam int CHAN_W      = 8;
   localparam int FRAC_W      = 16;
   localparam int COORD_W     = 20;
   localparam int QCOORD_W    = FRAC_W + 1;
   localparam int OUT_W       = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [QCOORD_W-1:0] ONE_Q16 = QCOORD_W'(1) << FRAC_W;

   // register indexes of the configuration port
   localparam logic CSR_TEX_WIDTH  = 1'b0;
   localparam logic CSR_TEX_HEIGHT = 1'b1;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   // one classified beat between front and back
   typedef struct packed {
      op_type              op;
      logic [ADDR_W-1:0]   idx_a;
      logic [ADDR_W-1:0]   idx_b;
      logic [ADDR_W-1:0]   idx_c;
      logic [ADDR_W-1:0]   idx_d;
      logic [TEXEL_W-1:0]  texel;
      logic [FRAC_W-1:0]   frac_s;
      logic [FRAC_W-1:0]   frac_t;
   } entry_type;

endpackage

>>> hdl/bts_front.sv
// ----------------------------------------------------------------------------
// bts_front
// accepts beats, clamps and scales coordinates, forms the corner addresses
// ----------------------------------------------------------------------------
module bts_front import bts_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                req_op,
   input  logic [ADDR_W-1:0]   req_texel_addr,
   input  logic [CHAN_W-1:0]   req_texel_red,
   input  logic [CHAN_W-1:0]   req_texel_green,
   input  logic [CHAN_W-1:0]   req_texel_blue,
   input  logic [COORD_W-1:0]  req_u_coord,
   input  logic [COORD_W-1:0]  req_v_coord,
   input  logic [SIDE_W-1:0]   tex_width,
   input  logic [SIDE_W-1:0]   tex_height,
   output logic                push,
   output entry_type           push_entry
);

   function automatic logic [QCOORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] raw);
      logic [QCOORD_W-1:0] r;
      r = raw[QCOORD_W-1:0];
      if (raw[COORD_W-1]) r = '0;
      else if (raw > COORD_W'(ONE_Q16)) r = ONE_Q16;
      return r;
   endfunction

   function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] s);
      logic [SIDE_W-1:0] r;
      r = s;
      if (s == '0) r = SIDE_W'(1);
      else if (s > SIDE_W'(MAX_SIDE)) r = SIDE_W'(MAX_SIDE);
      return r;
   endfunction

   // stage 1: clamp
   logic                    f1_valid_ff;
   op_type                  f1_op_ff;
   logic [ADDR_W-1:0]       f1_addr_ff;
   logic [TEXEL_W-1:0]      f1_texel_ff;
   logic [QCOORD_W-1:0]     f1_cu_ff, f1_cv_ff;
   logic [SIDE_W-1:0]       f1_w_ff, f1_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= accept;
      end
      f1_op_ff    <= op_type'(req_op);
      f1_addr_ff  <= req_texel_addr;
      f1_texel_ff <= {req_texel_red, req_texel_green, req_texel_blue};
      f1_cu_ff    <= clamp_coord(req_u_coord);
      f1_cv_ff    <= clamp_coord(req_v_coord);
      f1_w_ff     <= clamp_side(tex_width);
      f1_h_ff     <= clamp_side(tex_height);
   end

   // stage 2: scale by side minus one
   logic [QCOORD_W+CELL_W-1:0] su_in, sv_in;
   logic [QCOORD_W+CELL_W-1:0] f2_su_ff, f2_sv_ff;
   logic                       f2_valid_ff;
   op_type                     f2_op_ff;
   logic [ADDR_W-1:0]          f2_addr_ff;
   logic [TEXEL_W-1:0]         f2_texel_ff;
   logic [SIDE_W-1:0]          f2_w_ff;

   always_comb begin
      su_in = f1_cu_ff * CELL_W'(f1_w_ff - SIDE_W'(1));
      sv_in = f1_cv_ff * CELL_W'(f1_h_ff - SIDE_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_valid_ff <= 1'b0;
      end else begin
         f2_valid_ff <= f1_valid_ff;
      end
      f2_op_ff    <= f1_op_ff;
      f2_addr_ff  <= f1_addr_ff;
      f2_texel_ff <= f1_texel_ff;
      f2_su_ff    <= su_in;
      f2_sv_ff    <= sv_in;
      f2_w_ff     <= f1_w_ff;
   end

   // corner addresses, registered in the queue
   logic [CELL_W-1:0]        ul, uh, vl, vh;
   logic [FRAC_W-1:0]        fs, ft;
   logic [SIDE_W+CELL_W-1:0] row_lo, row_hi;

   always_comb begin
      ul     = f2_su_ff[FRAC_W +: CELL_W];
      vl     = f2_sv_ff[FRAC_W +: CELL_W];
      fs     = f2_su_ff[FRAC_W-1:0];
      ft     = f2_sv_ff[FRAC_W-1:0];
      uh     = ul + CELL_W'(fs != '0);
      vh     = vl + CELL_W'(ft != '0);
      row_lo = vl * f2_w_ff;
      row_hi = vh * f2_w_ff;

      push              = f2_valid_ff;
      push_entry.op     = f2_op_ff;
      push_entry.texel  = f2_texel_ff;
      push_entry.frac_s = fs;
      push_entry.frac_t = ft;
      push_entry.idx_b  = ADDR_W'(row_lo + (SIDE_W+CELL_W)'(uh));
      push_entry.idx_c  = ADDR_W'(row_hi + (SIDE_W+CELL_W)'(uh));
      push_entry.idx_d  = ADDR_W'(row_hi + (SIDE_W+CELL_W)'(ul));
      if (f2_op_ff == OP_LOAD) begin
         push_entry.idx_a = f2_addr_ff;
      end else begin
         push_entry.idx_a = ADDR_W'(row_lo + (SIDE_W+CELL_W)'(ul));
      end
   end

endmodule

>>> hdl/bts_queue.sv
// ----------------------------------------------------------------------------
// bts_queue
// short fifo between the front and the back
// ----------------------------------------------------------------------------
module bts_queue import bts_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  entry_type         push_entry,
   input  logic              pop,
   output logic              not_empty,
   output entry_type         head,
   output logic [QPTR_W:0]   count
);

   entry_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]     count_ff;
   logic                do_pop;

   assign do_pop    = pop && (count_ff != '0);
   assign not_empty = count_ff != '0;
   assign head      = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         count_ff <= count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(do_pop);
      end
      if (push) slot_ff[wr_ptr_ff] <= push_entry;
   end

   ap_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != (QPTR_W+1)'(QUEUE_DEPTH)) || do_pop)
      else $error("queue overflow");

   ap_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_W+1)'(QUEUE_DEPTH))
      else $error("queue count out of range");

endmodule

>>> hdl/bts_back.sv
// ----------------------------------------------------------------------------
// bts_back
// texel store access and bilinear blend
// ----------------------------------------------------------------------------
module bts_back import bts_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop,
   input  entry_type         head,
   output logic              rsp_valid,
   output logic [OUT_W-1:0]  rsp_red_out,
   output logic [OUT_W-1:0]  rsp_green_out,
   output logic [OUT_W-1:0]  rsp_blue_out
);

   localparam int WGT_W  = 2 * QCOORD_W;
   localparam int PROD_W = WGT_W + CHAN_W;
   localparam int SUM_W  = PROD_W + 2;

   // two copies of the store, two read ports each
   logic [TEXEL_W-1:0] mem0 [STORE_DEPTH];
   logic [TEXEL_W-1:0] mem1 [STORE_DEPTH];

   // stage 1: address register
   logic       b1_valid_ff;
   entry_type  b1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= pop;
      end
      b1_ff <= head;
   end

   // stage 2: store read or write, weights
   logic                b2_sample_ff;
   logic [TEXEL_W-1:0]  b2_a_ff, b2_b_ff, b2_c_ff, b2_d_ff;
   logic [WGT_W-1:0]    b2_wa_ff, b2_wb_ff, b2_wc_ff, b2_wd_ff;
   logic [QCOORD_W-1:0] is, it;

   always_comb begin
      is = ONE_Q16 - QCOORD_W'(b1_ff.frac_s);
      it = ONE_Q16 - QCOORD_W'(b1_ff.frac_t);
   end

   always_ff @(posedge clock) begin
      if (b1_valid_ff && (b1_ff.op == OP_LOAD)) begin
         mem0[b1_ff.idx_a] <= b1_ff.texel;
         mem1[b1_ff.idx_a] <= b1_ff.texel;
      end
      b2_a_ff <= mem0[b1_ff.idx_a];
      b2_b_ff <= mem0[b1_ff.idx_b];
      b2_c_ff <= mem1[b1_ff.idx_c];
      b2_d_ff <= mem1[b1_ff.idx_d];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b2_sample_ff <= 1'b0;
      end else begin
         b2_sample_ff <= b1_valid_ff && (b1_ff.op == OP_SAMPLE);
      end
      b2_wa_ff <= is * it;
      b2_wb_ff <= QCOORD_W'(b1_ff.frac_s) * it;
      b2_wc_ff <= QCOORD_W'(b1_ff.frac_s) * QCOORD_W'(b1_ff.frac_t);
      b2_wd_ff <= is * QCOORD_W'(b1_ff.frac_t);
   end

   // stage 3: weighted channels, one lane per channel
   logic              b3_valid_ff;
   logic [PROD_W-1:0] b3_p_ff [3][4];

   always_ff @(posedge clock) begin
      if (reset) begin
         b3_valid_ff <= 1'b0;
      end else begin
         b3_valid_ff <= b2_sample_ff;
      end
      for (int ch = 0; ch < 3; ch++) begin
         b3_p_ff[ch][0] <= b2_a_ff[ch*CHAN_W +: CHAN_W] * b2_wa_ff;
         b3_p_ff[ch][1] <= b2_b_ff[ch*CHAN_W +: CHAN_W] * b2_wb_ff;
         b3_p_ff[ch][2] <= b2_c_ff[ch*CHAN_W +: CHAN_W] * b2_wc_ff;
         b3_p_ff[ch][3] <= b2_d_ff[ch*CHAN_W +: CHAN_W] * b2_wd_ff;
      end
   end

   // stage 4: sum and truncate
   logic [SUM_W-1:0] sum [3];
   logic             rsp_valid_ff;
   logic [OUT_W-1:0] red_ff, green_ff, blue_ff;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         sum[ch] = SUM_W'(b3_p_ff[ch][0]) + SUM_W'(b3_p_ff[ch][1])
                 + SUM_W'(b3_p_ff[ch][2]) + SUM_W'(b3_p_ff[ch][3]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= b3_valid_ff;
      end
      red_ff   <= sum[2][2*FRAC_W-CHAN_W +: OUT_W];
      green_ff <= sum[1][2*FRAC_W-CHAN_W +: OUT_W];
      blue_ff  <= sum[0][2*FRAC_W-CHAN_W +: OUT_W];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = red_ff;
   assign rsp_green_out = green_ff;
   assign rsp_blue_out  = blue_ff;

   ap_sample_result: assert property (@(posedge clock) disable iff (reset)
      (pop && head.op == OP_SAMPLE) |-> ##4 rsp_valid)
      else $error("sample beat gave no result");

   ap_load_silent: assert property (@(posedge clock) disable iff (reset)
      (pop && head.op == OP_LOAD) |-> ##4 !rsp_valid)
      else $error("load beat gave a result");

endmodule

>>> hdl/bilinear_texture_sampler.sv
// ----------------------------------------------------------------------------
// bilinear_texture_sampler
// rgb texel store with bilinear sampling of clamped q3.16 coordinates
// ----------------------------------------------------------------------------
// a sample beat passes the front stages, the queue and the back stages before its result shows
// throughput: one beat per cycle while busy is low, loads and samples in any mix
// the store has two copies with two read ports each, so four corners per cycle
// busy rises only if the queue backs up; the result side cannot stall
// reset clears control and sets both sizes to 256; texels are undefined
module bilinear_texture_sampler import bts_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_op,
   input  logic [ADDR_W-1:0]   req_texel_addr,
   input  logic [CHAN_W-1:0]   req_texel_red,
   input  logic [CHAN_W-1:0]   req_texel_green,
   input  logic [CHAN_W-1:0]   req_texel_blue,
   input  logic [COORD_W-1:0]  req_u_coord,
   input  logic [COORD_W-1:0]  req_v_coord,
   output logic                rsp_valid,
   output logic [OUT_W-1:0]    rsp_red_out,
   output logic [OUT_W-1:0]    rsp_green_out,
   output logic [OUT_W-1:0]    rsp_blue_out,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [SIDE_W-1:0]   csr_wdata
);

   // size registers
   logic [SIDE_W-1:0] width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SIDE_W'(MAX_SIDE);
         height_ff <= SIDE_W'(MAX_SIDE);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TEX_WIDTH:  width_ff  <= csr_wdata;
            CSR_TEX_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic            accept;
   logic            push, q_not_empty;
   entry_type       push_entry, head;
   logic [QPTR_W:0] q_count;

   // the front holds up to two beats in flight, so keep that much room
   assign busy   = q_count >= (QPTR_W+1)'(QUEUE_DEPTH - 2);
   assign accept = start && !busy;

   bts_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .req_op          (req_op),
      .req_texel_addr  (req_texel_addr),
      .req_texel_red   (req_texel_red),
      .req_texel_green (req_texel_green),
      .req_texel_blue  (req_texel_blue),
      .req_u_coord     (req_u_coord),
      .req_v_coord     (req_v_coord),
      .tex_width       (width_ff),
      .tex_height      (height_ff),
      .push            (push),
      .push_entry      (push_entry)
   );

   bts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (q_not_empty),
      .not_empty  (q_not_empty),
      .head       (head),
      .count      (q_count)
   );

   // the back drains one beat every cycle
   bts_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop           (q_not_empty),
      .head          (head),
      .rsp_valid     (rsp_valid),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out)
   );

endmodule
